// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the FIR wall filter RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== hdl/fwf_pkg.sv =====
// Shared types and fixed constants of the FIR wall filter.
// No dependencies; imported by every fwf module except fwf_ram.
package fwf_pkg;

    // Fixed field widths
    localparam int COEF_BITS  = 18;
    localparam int OUT_BITS   = 40;
    localparam int TAP_W      = 6;
    localparam int IDX_W      = 5;

    // Coefficient digits consumed by the serial multiplier
    localparam int DIGIT_BITS = 6;
    localparam int NUM_DIGITS = COEF_BITS / DIGIT_BITS;
    localparam int DIG_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [DIG_W-1:0] DIG_LAST = DIG_W'(NUM_DIGITS - 1);

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MAC,
        ST_DONE
    } fwf_state_t;

    // Sequencer to datapath control
    typedef struct packed {
        logic             load;
        logic             step;
        logic [DIG_W-1:0] digit;
    } mac_ctrl_t;

endpackage

// ===== hdl/fwf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module fwf_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/fwf_coef_store.sv =====
// Coefficient tap store: RAM plus per-entry valid bits so unwritten taps read zero.
// Depends on fwf_pkg and fwf_ram.
module fwf_coef_store #(
    parameter int DEPTH = 32
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic signed [fwf_pkg::COEF_BITS-1:0]         wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic signed [fwf_pkg::COEF_BITS-1:0]         rdata
);
    import fwf_pkg::*;

    logic [DEPTH-1:0]     vld_reg;
    logic                 rd_vld_reg;
    logic [COEF_BITS-1:0] ram_q;

    // Mark entries as written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (we)
        begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    // Track validity of the entry being read, aligned with RAM output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else if (re)
        begin
            rd_vld_reg <= vld_reg[raddr];
        end
    end

    fwf_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (ram_q)
    );

    // Drop stale contents of never-written taps
    assign rdata = rd_vld_reg ? $signed(ram_q) : '0;

endmodule

// ===== hdl/fwf_mac.sv =====
// Digit-serial multiply-accumulate: sample shift line times coefficient digits.
// Depends on fwf_pkg.
module fwf_mac #(
    parameter int MAX_TAPS    = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                     clk,
    input  fwf_pkg::mac_ctrl_t                       ctrl,
    input  logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0]     window,
    input  logic signed [fwf_pkg::COEF_BITS-1:0]     coef,
    output logic signed [fwf_pkg::OUT_BITS-1:0]      result
);
    import fwf_pkg::*;

    localparam int ACC_BITS  = SAMPLE_BITS + COEF_BITS + $clog2(MAX_TAPS) + 1;
    localparam int PROD_BITS = SAMPLE_BITS + DIGIT_BITS + 1;
    localparam int SR_W      = COEF_BITS - DIGIT_BITS;
    localparam int EXT_W     = (ACC_BITS > OUT_BITS) ? ACC_BITS : OUT_BITS;
    localparam logic signed [EXT_W-1:0] SAT_HI =
        {{(EXT_W - OUT_BITS + 1){1'b0}}, {(OUT_BITS - 1){1'b1}}};
    localparam logic signed [EXT_W-1:0] SAT_LO = ~SAT_HI;

    logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0] work_reg, work_next;
    logic [SR_W-1:0]                      coef_sr_reg, coef_sr_next;
    logic signed [ACC_BITS-1:0]           acc_reg, acc_next;
    logic [DIGIT_BITS-1:0]                digit_raw;
    logic signed [DIGIT_BITS:0]           digit_s;
    logic signed [SAMPLE_BITS-1:0]        sample_cur;
    logic signed [PROD_BITS-1:0]          prod;
    logic signed [ACC_BITS-1:0]           partial;
    logic signed [EXT_W-1:0]              acc_ext;
    logic                                 tap_last_digit;

    assign tap_last_digit = ctrl.step && (ctrl.digit == DIG_LAST);
    assign sample_cur     = $signed(work_reg[0]);

    // Pick the current coefficient digit; only the top digit carries the sign
    always_comb
    begin
        if (ctrl.digit == '0)
        begin
            digit_raw    = coef[DIGIT_BITS-1:0];
            coef_sr_next = coef[COEF_BITS-1:DIGIT_BITS];
        end
        else
        begin
            digit_raw    = coef_sr_reg[DIGIT_BITS-1:0];
            coef_sr_next = coef_sr_reg >> DIGIT_BITS;
        end
        if (ctrl.digit == DIG_LAST)
        begin
            digit_s = {digit_raw[DIGIT_BITS-1], digit_raw};
        end
        else
        begin
            digit_s = {1'b0, digit_raw};
        end
    end

    // Weight the digit product by its position and accumulate
    always_comb
    begin
        prod     = sample_cur * digit_s;
        partial  = ACC_BITS'(prod) <<< (DIGIT_BITS * ctrl.digit);
        acc_next = acc_reg + partial;
    end

    // Advance the sample shift line one tap after the last digit
    always_comb
    begin
        for (int i = 0; i < MAX_TAPS - 1; i++)
        begin
            work_next[i] = work_reg[i + 1];
        end
        work_next[MAX_TAPS-1] = '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            work_reg <= window;
            acc_reg  <= '0;
        end
        else if (ctrl.step)
        begin
            coef_sr_reg <= coef_sr_next;
            acc_reg     <= acc_next;
            if (tap_last_digit)
            begin
                work_reg <= work_next;
            end
        end
    end

    // Clamp the sum to the output range
    always_comb
    begin
        acc_ext = EXT_W'(acc_reg);
        if (acc_ext > SAT_HI)
        begin
            result = {1'b0, {(OUT_BITS - 1){1'b1}}};
        end
        else if (acc_ext < SAT_LO)
        begin
            result = {1'b1, {(OUT_BITS - 1){1'b0}}};
        end
        else
        begin
            result = acc_ext[OUT_BITS-1:0];
        end
    end

endmodule

// ===== hdl/fir_wall_filter_core.sv =====
// Top level of the FIR wall filter: handshakes, sample window, tap sequencer.
// Depends on fwf_pkg, fwf_coef_store, fwf_mac and assert_macros.svh.
//
// Channel   Handshake              Payload
// ------    ---------------------  ------------------------------------------
// input     in_valid / in_stall    command, coef_index, coef_value, sample,
//                                  frame_start
// output    out_valid / out_stall  filtered
// config    cfg_valid / cfg_ready  tap_count
//
// A sample beat that completes a window starts a sum over the taps in use:
// one shared digit-serial MAC takes one 6-bit coefficient digit per cycle,
// three digits per tap, between a fetch state and a result state.
// Reset clears the tap store valid bits, fill count, tap count (to 1) and state.
// in_stall is high while a sum is being formed; a result waiting on out_stall
// holds in the output register while the next beat is taken.
`include "assert_macros.svh"

module fir_wall_filter_core #(
    parameter int MAX_TAPS    = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  command,
    input  logic [fwf_pkg::IDX_W-1:0]             coef_index,
    input  logic signed [fwf_pkg::COEF_BITS-1:0]  coef_value,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    input  logic                                  frame_start,
    // Output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [fwf_pkg::OUT_BITS-1:0]   filtered,
    // Configuration channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fwf_pkg::TAP_W-1:0]             tap_count
);
    import fwf_pkg::*;

    localparam int AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int FILL_W = $clog2(MAX_TAPS + 1);
    localparam int CMP_W  = (FILL_W > TAP_W) ? FILL_W : TAP_W;
    // One spare bit so the store depth itself is representable
    localparam int WIDX_W = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam logic [CMP_W-1:0]  MAX_CMP  = CMP_W'(MAX_TAPS);
    localparam logic [FILL_W-1:0] MAX_FILL = FILL_W'(MAX_TAPS);

    fwf_state_t                           state_reg, state_next;
    logic [AW-1:0]                        k_reg, k_next;
    logic [DIG_W-1:0]                     dig_reg, dig_next;
    logic [FILL_W-1:0]                    fill_reg, fill_next;
    logic [TAP_W-1:0]                     tap_reg;
    logic                                 out_valid_reg;
    logic signed [OUT_BITS-1:0]           filtered_reg;
    logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0] win_reg;

    logic                     in_accept;
    logic                     sample_beat;
    logic                     load_beat;
    logic                     out_accept;
    logic                     out_load;
    logic [CMP_W-1:0]         tap_ext;
    logic [CMP_W-1:0]         taps_eff;
    logic [FILL_W-1:0]        fill_base;
    logic                     window_full;
    logic [AW-1:0]            k_first;
    logic [WIDX_W-1:0]        idx_wide;
    logic                     idx_ok;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic signed [COEF_BITS-1:0] coef_q;
    logic signed [OUT_BITS-1:0]  mac_result;
    mac_ctrl_t                mac_ctrl;

    // Handshakes
    assign in_stall    = (state_reg != ST_IDLE);
    assign cfg_ready   = (state_reg == ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign sample_beat = in_accept && (command == CMD_SAMPLE);
    assign load_beat   = in_accept && (command == CMD_LOAD);
    assign out_accept  = out_valid_reg && !out_stall;
    assign out_valid   = out_valid_reg;
    assign filtered    = filtered_reg;

    // Clamp the tap count to 1..MAX_TAPS
    always_comb
    begin
        tap_ext = CMP_W'(tap_reg);
        if (tap_ext == '0)
        begin
            taps_eff = CMP_W'(1);
        end
        else if (tap_ext > MAX_CMP)
        begin
            taps_eff = MAX_CMP;
        end
        else
        begin
            taps_eff = tap_ext;
        end
        k_first = AW'(taps_eff - CMP_W'(1));
    end

    // Frame fill: restart on frame start, saturate at the window depth
    always_comb
    begin
        fill_base = frame_start ? '0 : fill_reg;
        if (fill_base < MAX_FILL)
        begin
            fill_next = fill_base + FILL_W'(1);
        end
        else
        begin
            fill_next = fill_base;
        end
        window_full = (CMP_W'(fill_next) >= taps_eff);
    end

    // Coefficient write address, ignoring taps beyond the store
    assign idx_wide = WIDX_W'(coef_index);
    assign idx_ok   = (idx_wide < WIDX_W'(MAX_TAPS));

    // Sequencer: fetch the last tap in use, then three digits per tap down to tap 0, newest sample first
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        dig_next       = dig_reg;
        mac_ctrl       = '0;
        mac_ctrl.digit = dig_reg;
        rd_en          = 1'b0;
        rd_addr        = k_reg;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_beat && window_full)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                rd_en         = 1'b1;
                rd_addr       = k_first;
                k_next        = k_first;
                dig_next      = '0;
                mac_ctrl.load = 1'b1;
                state_next    = ST_MAC;
            end
            ST_MAC:
            begin
                mac_ctrl.step = 1'b1;
                if (dig_reg == DIG_LAST)
                begin
                    dig_next = '0;
                    if (k_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = k_reg - AW'(1);
                        k_next  = k_reg - AW'(1);
                    end
                end
                else
                begin
                    dig_next = dig_reg + DIG_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            dig_reg       <= '0;
            fill_reg      <= '0;
            tap_reg       <= TAP_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            dig_reg   <= dig_next;
            if (sample_beat)
            begin
                fill_reg <= fill_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                tap_reg <= tap_count;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Shift a new sample into the window; hold the finished sum
    always_ff @(posedge clk)
    begin
        if (sample_beat)
        begin
            for (int i = MAX_TAPS - 1; i > 0; i--)
            begin
                win_reg[i] <= win_reg[i - 1];
            end
            win_reg[0] <= sample;
        end
        if (out_load)
        begin
            filtered_reg <= mac_result;
        end
    end

    fwf_coef_store #(
        .DEPTH (MAX_TAPS)
    ) u_coef_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (load_beat && idx_ok),
        .waddr (idx_wide[AW-1:0]),
        .wdata (coef_value),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (coef_q)
    );

    fwf_mac #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .window (win_reg),
        .coef   (coef_q),
        .result (mac_result)
    );

    // Checks
    `ASSERT_NEXT(a_load_no_sum, clk, rst_n, load_beat, state_reg == ST_IDLE, "load beat started a sum")
    `ASSERT_NEXT(a_full_starts_sum, clk, rst_n, sample_beat && window_full, state_reg == ST_FETCH, "full window did not start a sum")
    `ASSERT_NEXT(a_last_tap_done, clk, rst_n, state_reg == ST_MAC && dig_reg == DIG_LAST && k_reg == '0, state_reg == ST_DONE, "tap walk overran")
    `ASSERT_NEXT(a_result_posted, clk, rst_n, state_reg == ST_DONE && !(out_valid_reg && out_stall), out_valid && state_reg == ST_IDLE, "finished sum not posted")
    `ASSERT_IMPLY(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= MAX_FILL, "fill count beyond window depth")

endmodule

// ===== tb/fwf_checker.sv =====
// Scoreboard for the FIR wall filter: watches the config, input and output channels.
// Keeps its own tap store, sample window and fill count, and compares every output beat.
// Depends on fwf_pkg.
module fwf_checker #(
    parameter int MAX_TAPS    = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic                                  command,
    input  logic [fwf_pkg::IDX_W-1:0]             coef_index,
    input  logic signed [fwf_pkg::COEF_BITS-1:0]  coef_value,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    input  logic                                  frame_start,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic signed [fwf_pkg::OUT_BITS-1:0]   filtered,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [fwf_pkg::TAP_W-1:0]             tap_count,
    output int                                    fail_count,
    output int                                    pending_results,
    output int                                    result_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import fwf_pkg::*;

    logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] window   [MAX_TAPS];
    int unsigned                   fill;
    logic [TAP_W-1:0]              taps_reg;
    logic signed [OUT_BITS-1:0]    sums_due [$];

    // Clamp the programmed tap count to 1..MAX_TAPS
    function automatic int taps_in_use();
        if (taps_reg == 0)
            return 1;
        if (taps_reg > MAX_TAPS)
            return MAX_TAPS;
        return int'(taps_reg);
    endfunction

    // Newest sample meets the last coefficient; saturate to the output width
    function automatic logic signed [OUT_BITS-1:0] window_sum(int taps);
        longint acc;
        longint hi;
        longint lo;
        acc = 0;
        hi  = (longint'(1) <<< (OUT_BITS - 1)) - 1;
        lo  = -hi - 1;
        for (int k = 0; k < taps; k++)
            acc += longint'(window[taps - 1 - k]) * longint'(coef_mem[k]);
        if (acc > hi)
            acc = hi;
        if (acc < lo)
            acc = lo;
        return acc[OUT_BITS-1:0];
    endfunction

    // Apply one accepted input beat to the model
    task automatic take_beat();
        int taps;
        if (command == CMD_LOAD)
        begin
            if (coef_index < MAX_TAPS)
                coef_mem[coef_index] = coef_value;
        end
        else
        begin
            if (frame_start)
                fill = 0;
            for (int i = MAX_TAPS - 1; i > 0; i--)
                window[i] = window[i - 1];
            window[0] = sample;
            if (fill < MAX_TAPS)
                fill++;
            taps = taps_in_use();
            if (fill >= taps)
                sums_due.push_back(window_sum(taps));
        end
    endtask

    // Compare one output beat against the oldest expected sum
    task automatic check_result();
        logic signed [OUT_BITS-1:0] want;
        if (sums_due.size() == 0)
        begin
            $error("filtered: no result expected, actual %0d", filtered);
            fail_count <= fail_count + 1;
        end
        else
        begin
            want = sums_due.pop_front();
            result_count <= result_count + 1;
            if (filtered !== want)
            begin
                $error("filtered: expected %0d, actual %0d", want, filtered);
                fail_count <= fail_count + 1;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            // Hold the model at its reset state
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                coef_mem[i] = '0;
                window[i]   = '0;
            end
            fill     = 0;
            taps_reg = TAP_W'(1);
            sums_due.delete();
            pending_results <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                taps_reg = tap_count;
            // Check outputs before this edge's input can add an expectation
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                take_beat();
            pending_results <= sums_due.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the FIR wall filter bench: clock, reset, stimulus and the final verdict.
// Instantiates fir_wall_filter_core and fwf_checker; depends on fwf_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fwf_pkg::*;

    localparam int MAX_TAPS      = 32;
    localparam int SAMPLE_BITS   = 16;
    localparam int RANDOM_ITEMS  = 450;
    localparam int SETTLE_CYCLES = 128;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          in_valid    = 1'b0;
    logic                          in_stall;
    logic                          command     = 1'b0;
    logic [IDX_W-1:0]              coef_index  = '0;
    logic signed [COEF_BITS-1:0]   coef_value  = '0;
    logic signed [SAMPLE_BITS-1:0] sample      = '0;
    logic                          frame_start = 1'b0;
    logic                          out_valid;
    logic                          out_stall   = 1'b0;
    logic signed [OUT_BITS-1:0]    filtered;
    logic                          cfg_valid   = 1'b0;
    logic                          cfg_ready;
    logic [TAP_W-1:0]              tap_count   = TAP_W'(1);

    int fail_count;
    int pending_results;
    int result_count;
    int beats_sent;
    int directed_beats;
    int tap_writes;
    bit idle_on = 1'b1;

    always #5 clk = ~clk;

    fir_wall_filter_core #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .coef_index  (coef_index),
        .coef_value  (coef_value),
        .sample      (sample),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .filtered    (filtered),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .tap_count   (tap_count)
    );

    fwf_checker #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .coef_index      (coef_index),
        .coef_value      (coef_value),
        .sample          (sample),
        .frame_start     (frame_start),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .filtered        (filtered),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .tap_count       (tap_count),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .result_count    (result_count)
    );

    // Stall the output channel at random while idling is enabled
    always @(posedge clk)
        out_stall <= idle_on && ($urandom_range(99) < 22);

    // Drive one input beat, with an optional gap first, and wait for acceptance
    task automatic send_beat(input cmd_t cmd, input logic [IDX_W-1:0] idx,
                             input logic signed [COEF_BITS-1:0] cv,
                             input logic signed [SAMPLE_BITS-1:0] smp, input logic fs);
        if (idle_on && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        coef_index  <= idx;
        coef_value  <= cv;
        sample      <= smp;
        frame_start <= fs;
        do @(posedge clk); while (in_stall);
        beats_sent++;
    endtask

    task automatic load_coef(input logic [IDX_W-1:0] idx, input logic signed [COEF_BITS-1:0] cv);
        send_beat(CMD_LOAD, idx, cv, SAMPLE_BITS'($urandom), 1'($urandom));
    endtask

    task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic fs);
        send_beat(CMD_SAMPLE, IDX_W'($urandom), COEF_BITS'($urandom), smp, fs);
    endtask

    // Drop valid, drain every expected sum, then let the sequencer go quiet
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the tap count register; only called when the block is idle
    task automatic write_taps(input logic [TAP_W-1:0] value);
        cfg_valid <= 1'b1;
        tap_count <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tap_writes++;
    endtask

    // Mostly full-range values, with the extremes and zero mixed in
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2:       return '0;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic signed [COEF_BITS-1:0] pick_coef();
        case ($urandom_range(9))
            0:       return {1'b0, {(COEF_BITS-1){1'b1}}};
            1:       return {1'b1, {(COEF_BITS-1){1'b0}}};
            default: return COEF_BITS'($urandom);
        endcase
    endfunction

    // Hard stop for a hung run
    initial
    begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int               phase;
        int               eff;
        int               len;
        int               roll;
        bit               fs_first;
        logic [TAP_W-1:0] taps_sel;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single tap at reset value, coefficient extremes and index extremes
        load_coef(0, -131072);
        push_sample(16'sh7FFF, 1'b1);
        push_sample(16'sh8000, 1'b0);
        load_coef(0, 131071);
        push_sample(16'sh8000, 1'b0);
        load_coef(31, -131072);
        push_sample(16'sh0000, 1'b0);

        // Zero tap count behaves as one tap
        settle();
        write_taps(0);
        push_sample(1, 1'b0);

        // Four taps: window fills, then a frame start empties it
        settle();
        write_taps(4);
        load_coef(1, 18'sh15555);
        load_coef(2, -77);
        load_coef(3, 65536);
        push_sample(16'sh5555, 1'b1);
        push_sample(16'shAAAA, 1'b0);
        push_sample(7, 1'b0);
        push_sample(-7, 1'b0);
        push_sample(100, 1'b1);

        // Tap count changed inside a frame takes effect at once
        settle();
        write_taps(2);
        push_sample(200, 1'b0);
        settle();
        write_taps(3);
        push_sample(300, 1'b0);
        directed_beats = beats_sent;

        // Random phases: each drains, picks a tap count, reloads taps, streams frames
        phase = 0;
        while (beats_sent - directed_beats < RANDOM_ITEMS)
        begin
            settle();
            idle_on = !(phase >= 4 && phase <= 6);
            roll    = $urandom_range(99);
            if (phase == 0)
                taps_sel = TAP_W'(MAX_TAPS);
            else if (phase == 1)
                taps_sel = '1;
            else if (roll < 60)
                taps_sel = TAP_W'($urandom_range(1, 8));
            else if (roll < 80)
                taps_sel = TAP_W'($urandom_range(9, MAX_TAPS - 1));
            else if (roll < 88)
                taps_sel = TAP_W'(MAX_TAPS);
            else if (roll < 96)
                taps_sel = TAP_W'($urandom_range(MAX_TAPS + 1, 63));
            else
                taps_sel = '0;
            write_taps(taps_sel);
            eff = (taps_sel == 0) ? 1 : ((taps_sel > MAX_TAPS) ? MAX_TAPS : int'(taps_sel));

            // Reload part of the tap store, mostly within the taps in use
            repeat ($urandom_range(0, eff))
            begin
                if ($urandom_range(4) != 0)
                    load_coef(IDX_W'($urandom_range(0, eff - 1)), pick_coef());
                else
                    load_coef(IDX_W'($urandom), pick_coef());
            end

            // Frames: mostly long enough to fill the window, a few cut short
            for (int f = 0; f < $urandom_range(1, 3); f++)
            begin
                fs_first = (f > 0) || ($urandom_range(3) != 0);
                if ($urandom_range(9) == 0)
                    len = $urandom_range(1, eff);
                else
                    len = eff + $urandom_range(0, 12);
                for (int j = 0; j < len; j++)
                begin
                    if ($urandom_range(9) == 0)
                        load_coef(IDX_W'($urandom), pick_coef());
                    push_sample(pick_sample(), (j == 0) && fs_first);
                end
            end
            phase++;
        end

        // Drain the tail and report
        idle_on = 1'b1;
        settle();
        $display("Summary: %0d input beats (%0d directed) over %0d tap-count writes, %0d sums checked",
                 beats_sent, directed_beats, tap_writes, result_count);
        $display("Tap settings spanned zero, one, the full store and out-of-range counts");
        if (fail_count == 0 && pending_results == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== fir_wall_filter_core.f =====
+incdir+hdl
hdl/fwf_pkg.sv
hdl/fwf_ram.sv
hdl/fwf_coef_store.sv
hdl/fwf_mac.sv
hdl/fir_wall_filter_core.sv
tb/fwf_checker.sv
tb/testbench.sv
